// ----- hw/rtl/olid_pkg.sv -----
// package for the ordered list block
// request codes, status codes and the command bundle broadcast to the cells
`default_nettype none

package olid_pkg;

  localparam int CAPACITY_DEFAULT = 16;
  localparam int VALUE_W = 32;

  typedef enum logic [1:0] {
    OP_INS_FRONT = 2'd0,
    OP_INS_BACK  = 2'd1,
    OP_DELETE    = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic ins_front;
    logic ins_back;
    logic del_req;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ordered_list_insert_delete_top.sv -----
// top level of the ordered list with insert at either end and delete by key
// row of olid_cell instances plus count, status and response handshake; uses olid_pkg
//
//  channel   direction  handshake              payload
//  request   in         req_valid / req_ready  operation, value
//  response  out        rsp_valid / rsp_ready  status, entry_count, front_value, back_value
//
// one request per cycle while responses are taken; each request updates the
// whole cell row in the cycle it is accepted, the first-match search rippling
// through the cells; the response shows the next cycle.
// reset clears the count and response valid; entries are left as they are.
// a pending response holds off new requests until it is taken.
`default_nettype none

module ordered_list_insert_delete_top #(
  parameter int CAPACITY = olid_pkg::CAPACITY_DEFAULT,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                req_valid,
  output logic                                     req_ready,
  input  wire logic [1:0]                          operation,
  input  wire logic signed [olid_pkg::VALUE_W-1:0] value,
  output logic                                     rsp_valid,
  input  wire logic                                rsp_ready,
  output logic [1:0]                               status,
  output logic [CNT_W-1:0]                         entry_count,
  output logic signed [olid_pkg::VALUE_W-1:0]      front_value,
  output logic signed [olid_pkg::VALUE_W-1:0]      back_value
);
  import olid_pkg::*;

  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

  logic                 accept;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  status_t              rsp_status;
  status_t              status_next;
  cell_cmd_t            cmd;
  logic [VALUE_W-1:0]   key;
  logic                 full;
  logic                 empty;

  logic [VALUE_W-1:0]   cell_value [CAPACITY];
  logic [VALUE_W-1:0]   cell_tail  [CAPACITY];
  logic                 found_chain [CAPACITY+1];
  logic [VALUE_W-1:0]   tail_or;

  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;
  assign key       = value;
  assign full      = count == FULL_COUNT;
  assign empty     = count == '0;
  assign found_chain[0] = 1'b0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VALUE_W-1:0] left_value;
    logic [VALUE_W-1:0] right_value;

    if (g == 0) begin : g_first
      assign left_value = key;
    end else begin : g_mid_l
      assign left_value = cell_value[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_value = cell_value[g];
    end else begin : g_mid_r
      assign right_value = cell_value[g+1];
    end

    olid_cell #(
      .CNT_W (CNT_W),
      .INDEX (g)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .key         (key),
      .count       (count),
      .left_value  (left_value),
      .right_value (right_value),
      .found_in    (found_chain[g]),
      .found_out   (found_chain[g+1]),
      .value       (cell_value[g]),
      .tail_value  (cell_tail[g])
    );
  end

  always_comb begin
    cmd         = '0;
    status_next = ST_OK;
    count_next  = count;
    unique case (operation)
      OP_INS_FRONT, OP_INS_BACK: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          cmd.ins_front = accept && (operation == OP_INS_FRONT);
          cmd.ins_back  = accept && (operation == OP_INS_BACK);
          count_next    = count + 1'b1;
        end
      end
      OP_DELETE: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else if (found_chain[CAPACITY]) begin
          cmd.del_req = accept;
          count_next  = count - 1'b1;
        end else begin
          status_next = ST_NOTFOUND;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      rsp_valid  <= 1'b0;
      rsp_status <= ST_OK;
    end else begin
      if (accept) begin
        count      <= count_next;
        rsp_status <= status_next;
        rsp_valid  <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid  <= 1'b0;
      end
    end
  end

  // back entry is the only cell whose tail output can be nonzero
  always_comb begin
    tail_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      tail_or = tail_or | cell_tail[i];
    end
  end

  assign status      = rsp_status;
  assign entry_count = count;
  assign front_value = empty ? '0 : cell_value[0];
  assign back_value  = tail_or;

endmodule

`default_nettype wire

// ----- hw/rtl/olid_cell.sv -----
// one storage cell of the ordered list row
// holds one entry, shifts toward either neighbor; depends on olid_pkg
`default_nettype none

module olid_cell #(
  parameter int CNT_W = 5,
  parameter int INDEX = 0
) (
  input  wire logic                          clk,
  input  wire olid_pkg::cell_cmd_t           cmd,
  input  wire logic [olid_pkg::VALUE_W-1:0]  key,
  input  wire logic [CNT_W-1:0]              count,
  input  wire logic [olid_pkg::VALUE_W-1:0]  left_value,
  input  wire logic [olid_pkg::VALUE_W-1:0]  right_value,
  input  wire logic                          found_in,
  output logic                               found_out,
  output logic [olid_pkg::VALUE_W-1:0]       value,
  output logic [olid_pkg::VALUE_W-1:0]       tail_value
);
  import olid_pkg::*;

  localparam logic [CNT_W-1:0] IDX  = CNT_W'(INDEX);
  localparam logic [CNT_W-1:0] IDX1 = CNT_W'(INDEX + 1);

  logic                 occupied;
  logic [VALUE_W-1:0]   value_next;

  assign occupied  = IDX < count;
  assign found_out = found_in | (occupied && (value == key));
  assign tail_value = (count == IDX1) ? value : '0;

  always_comb begin
    value_next = value;
    priority if (cmd.ins_front) begin
      value_next = left_value;
    end else if (cmd.ins_back && (count == IDX)) begin
      value_next = key;
    end else if (cmd.del_req && found_out) begin
      value_next = right_value;
    end else begin
      value_next = value;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

`default_nettype wire

// ----- dv/olid_list_checker.sv -----
`timescale 1ns / 1ps
// response checker for ordered_list_insert_delete_top: keeps its own copy of the list,
// predicts one response per accepted request and compares it in order; uses olid_pkg
module olid_list_checker #(
  parameter int CAPACITY = olid_pkg::CAPACITY_DEFAULT,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                req_valid,
  input  wire logic                                req_ready,
  input  wire logic [1:0]                          operation,
  input  wire logic signed [olid_pkg::VALUE_W-1:0] value,
  input  wire logic                                rsp_valid,
  input  wire logic                                rsp_ready,
  input  wire logic [1:0]                          status,
  input  wire logic [CNT_W-1:0]                    entry_count,
  input  wire logic signed [olid_pkg::VALUE_W-1:0] front_value,
  input  wire logic signed [olid_pkg::VALUE_W-1:0] back_value,
  output int                                       failures,
  output int                                       pending
);
  import olid_pkg::*;

  typedef struct packed {
    status_t                   st;
    logic [CNT_W-1:0]          count;
    logic signed [VALUE_W-1:0] front;
    logic signed [VALUE_W-1:0] back;
  } list_result_t;

  logic signed [VALUE_W-1:0] list_mem [CAPACITY];
  int list_len = 0;
  list_result_t expected_q [$];
  int fail_count = 0;
  int pending_count = 0;

  assign failures = fail_count;
  assign pending  = pending_count;

  function automatic list_result_t apply_request(input logic [1:0] op,
                                                 input logic signed [VALUE_W-1:0] v);
    list_result_t r;
    int hit;
    r.st = ST_OK;
    case (op)
      OP_INS_FRONT, OP_INS_BACK: begin
        if (list_len >= CAPACITY) begin
          r.st = ST_FULL;
        end else if (op == OP_INS_FRONT) begin
          for (int i = list_len; i > 0; i--) list_mem[i] = list_mem[i-1];
          list_mem[0] = v;
          list_len++;
        end else begin
          list_mem[list_len] = v;
          list_len++;
        end
      end
      OP_DELETE: begin
        if (list_len == 0) begin
          r.st = ST_EMPTY;
        end else begin
          hit = -1;
          for (int i = list_len - 1; i >= 0; i--) if (list_mem[i] == v) hit = i;
          if (hit < 0) begin
            r.st = ST_NOTFOUND;
          end else begin
            for (int i = hit; i < list_len - 1; i++) list_mem[i] = list_mem[i+1];
            list_len--;
          end
        end
      end
      default: ;
    endcase
    r.count = CNT_W'(list_len);
    r.front = (list_len == 0) ? '0 : list_mem[0];
    r.back  = (list_len == 0) ? '0 : list_mem[list_len-1];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint want, input longint got);
    fail_count++;
    $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
  endtask

  always @(posedge clk) begin
    list_result_t want;
    if (rst) begin
      list_len = 0;
      expected_q.delete();
      pending_count <= 0;
    end else begin
      // pop before push: a response never belongs to the request taken at the same edge
      if (rsp_valid && rsp_ready) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 50)
            $display("%0t: response with no request waiting, status %0d count %0d",
                     $time, status, entry_count);
        end else begin
          want = expected_q.pop_front();
          if (status !== want.st) report_mismatch("status", want.st, status);
          if (entry_count !== want.count) report_mismatch("entry_count", want.count, entry_count);
          if (front_value !== want.front) report_mismatch("front_value", want.front, front_value);
          if (back_value !== want.back) report_mismatch("back_value", want.back, back_value);
        end
      end
      if (req_valid && req_ready) expected_q.push_back(apply_request(operation, value));
      pending_count <= expected_q.size();
    end
  end
endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// testbench top for ordered_list_insert_delete_top: clock, reset, request stimulus and
// response back-pressure; depends on olid_pkg and olid_list_checker for the verdict
module tb;
  import olid_pkg::*;

  localparam int CAP   = CAPACITY_DEFAULT;
  localparam int CNT_W = $clog2(CAP + 1);
  localparam logic [1:0] OP_RESERVED = 2'd3;
  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  localparam int MODE_FILL  = 0;
  localparam int MODE_DRAIN = 1;
  localparam int MODE_MIXED = 2;

  logic clk, rst;
  logic req_valid, req_ready, rsp_valid, rsp_ready;
  logic [1:0] operation, status;
  logic signed [VALUE_W-1:0] value, front_value, back_value;
  logic [CNT_W-1:0] entry_count;

  int req_idle_pct, rsp_stall_pct;
  bit long_hold;
  int chk_failures, chk_pending;
  logic signed [VALUE_W-1:0] key_pool [6];

  ordered_list_insert_delete_top #(.CAPACITY(CAP)) u_top (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .operation(operation), .value(value),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .status(status),
    .entry_count(entry_count), .front_value(front_value), .back_value(back_value)
  );

  olid_list_checker #(.CAPACITY(CAP)) u_checker (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .operation(operation), .value(value),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .status(status),
    .entry_count(entry_count), .front_value(front_value), .back_value(back_value),
    .failures(chk_failures), .pending(chk_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // response back-pressure, with a long hold-off whenever long_hold is set
  initial begin
    int hold_left;
    hold_left = 0;
    rsp_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && long_hold) begin
        hold_left = 80;
        long_hold = 1'b0;
      end
      if (hold_left > 0) begin
        rsp_ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("ordered_list_insert_delete_top verification failed");
    $finish;
  end

  task automatic send_request(input logic [1:0] op, input logic signed [VALUE_W-1:0] v);
    @(negedge clk);
    while ($urandom_range(0, 99) < req_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    operation <= op;
    value     <= v;
    do @(posedge clk); while (!req_ready);
  endtask

  task automatic wait_all_responses();
    @(negedge clk);
    req_valid <= 1'b0;
    while (chk_pending != 0) @(negedge clk);
  endtask

  task automatic set_idling(input int send_idle, input int recv_stall);
    @(posedge clk);
    req_idle_pct  = send_idle;
    rsp_stall_pct = recv_stall;
  endtask

  function automatic logic signed [VALUE_W-1:0] extreme_value();
    case ($urandom_range(0, 3))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  function automatic logic signed [VALUE_W-1:0] fresh_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return $signed($urandom_range(0, 31)) - 16;
    if (r < 90) return $urandom;
    return extreme_value();
  endfunction

  task automatic run_random(input int total);
    int left, seg_len, mode, r;
    logic [1:0] op;
    logic signed [VALUE_W-1:0] v;
    left = total;
    while (left > 0) begin
      seg_len = $urandom_range(8, 40);
      if (seg_len > left) seg_len = left;
      mode = $urandom_range(MODE_FILL, MODE_MIXED);
      if ($urandom_range(0, 99) < 30)
        foreach (key_pool[k]) key_pool[k] = fresh_key();
      repeat (seg_len) begin
        r = $urandom_range(0, 99);
        case (mode)
          MODE_FILL:  op = (r < 38) ? OP_INS_FRONT : (r < 75) ? OP_INS_BACK :
                           (r < 97) ? OP_DELETE : OP_RESERVED;
          MODE_DRAIN: op = (r < 15) ? OP_INS_FRONT : (r < 30) ? OP_INS_BACK :
                           (r < 97) ? OP_DELETE : OP_RESERVED;
          default:    op = (r < 30) ? OP_INS_FRONT : (r < 60) ? OP_INS_BACK :
                           (r < 97) ? OP_DELETE : OP_RESERVED;
        endcase
        r = $urandom_range(0, 99);
        if (op == OP_DELETE)
          v = (r < 85) ? key_pool[$urandom_range(0, 5)] : $urandom;
        else
          v = (r < 80) ? key_pool[$urandom_range(0, 5)] :
              (r < 95) ? $urandom : extreme_value();
        send_request(op, v);
      end
      left -= seg_len;
    end
  endtask

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    operation = OP_INS_FRONT;
    value = '0;
    req_idle_pct = 0;
    rsp_stall_pct = 0;
    long_hold = 1'b0;
    foreach (key_pool[k]) key_pool[k] = k;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty list, unused code, extremes, absent key, duplicates, full
    send_request(OP_DELETE, '0);
    send_request(OP_RESERVED, '0);
    send_request(OP_INS_BACK, VAL_MAX);
    send_request(OP_INS_FRONT, VAL_MIN);
    send_request(OP_INS_BACK, '1);
    send_request(OP_DELETE, 32'sd5);
    send_request(OP_DELETE, VAL_MIN);
    send_request(OP_INS_FRONT, 32'sd7);
    send_request(OP_INS_BACK, 32'sd7);
    send_request(OP_DELETE, 32'sd7);
    send_request(OP_RESERVED, 32'sd1);
    for (int i = 0; i < CAP - 3; i++)
      send_request((i % 2 == 0) ? OP_INS_FRONT : OP_INS_BACK,
                   (i % 2 == 0) ? 32'sh5555_5555 + i : 32'shaaaa_aaaa - i);
    send_request(OP_INS_BACK, 32'sd9);
    send_request(OP_INS_FRONT, 32'sd9);
    wait_all_responses();

    set_idling(0, 0);
    run_random(200);
    long_hold = 1'b1;
    run_random(250);
    wait_all_responses();

    set_idling(75, 0);
    run_random(350);
    wait_all_responses();

    set_idling(0, 75);
    run_random(350);
    wait_all_responses();

    set_idling(28, 28);
    run_random(350);
    wait_all_responses();

    repeat (8) @(negedge clk);
    if (chk_failures == 0 && chk_pending == 0)
      $display("ordered_list_insert_delete_top verification clean");
    else
      $display("ordered_list_insert_delete_top verification failed");
    $finish;
  end
endmodule
